@@ src/bgauge_pkg.sv @@
// Shared constants, types and command/status bundles of the battery gauge.
package bgauge_pkg;

  // Register file
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_TOP    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOTTOM = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EMPTY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FULL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN   = 3'd4;

  localparam logic [CFG_W-1:0] TOP_RST    = 16'd100;
  localparam logic [CFG_W-1:0] BOTTOM_RST = 16'd100;
  localparam logic [CFG_W-1:0] EMPTY_RST  = 16'd3300;
  localparam logic [CFG_W-1:0] FULL_RST   = 16'd4200;
  localparam logic [CFG_W-1:0] GAIN_RST   = 16'd9830;

  // Field widths
  localparam int MV_W    = 12;
  localparam int PCT_W   = 7;
  localparam int SUM_W   = 21;
  localparam int TREND_W = 22;
  localparam int ACC_W   = 32;

  // Window length default
  localparam int WINDOW_LEN_DEF = 16;

  // Divider: dividend is mv * (top + bottom), 12 + 17 bits
  localparam int NUM_W       = MV_W + CFG_W + 1;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int SCALE_ITERS = NUM_W;
  localparam int PCT_ITERS   = CFG_W;

  // Percent step = span / 100 via reciprocal multiply (exact for 16-bit span)
  localparam logic [16:0] PCT_RECIP = 17'd83887;
  localparam int          PCT_SHIFT = 23;
  localparam int          STEP_W    = 10;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic num_mul;
    logic div_scale;
    logic scale_sat;
    logic scale_quot;
    logic flt_mul;
    logic flt_add;
    logic win_add;
    logic win_close;
    logic pct_div;
    logic pct_direct;
    logic pct_quot;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bot_zero;
    logic pct_skip;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ src/bgauge_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module bgauge_div #(
  parameter int DVD_W = bgauge_pkg::NUM_W,
  parameter int DVS_W = bgauge_pkg::CFG_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [DVS_W-1:0]             divisor,
  input  logic [$clog2(DVD_W+1)-1:0]   iters,
  output logic                         done,
  output logic [DVD_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  // One shift/subtract step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // A new division never starts on top of a running one
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

@@ src/bgauge_dp.sv @@
// Datapath: config registers, scaling, filter, window trend, percent, output register.
module bgauge_dp #(
  parameter int WINDOW_LEN = bgauge_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bgauge_pkg::cmd_t                    cmd,
  output bgauge_pkg::sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [bgauge_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bgauge_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [bgauge_pkg::MV_W-1:0]         in_sample_mv,
  input  logic                                in_soft_mode,
  input  logic                                in_charge_pin,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [15:0]                         out_filtered_mv,
  output logic [bgauge_pkg::PCT_W-1:0]        out_charge_percent,
  output logic                                out_charging,
  output logic signed [bgauge_pkg::TREND_W-1:0] out_window_trend
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = bgauge_pkg::SUM_W;
  localparam int NUM_W = bgauge_pkg::NUM_W;
  localparam int PCT_W = bgauge_pkg::PCT_W;

  // Config registers
  logic [15:0] top_r, bot_r, empty_r, full_r, gain_r;

  // Item registers
  logic [bgauge_pkg::MV_W-1:0] mv_r;
  logic                        soft_r;
  logic                        pin_r;
  logic [NUM_W-1:0]            num_r;
  logic [15:0]                 scaled_r;
  logic [48:0]                 p1_r;
  logic [31:0]                 p2_r;
  logic [32:0]                 step_prod_r;
  logic [PCT_W-1:0]            pct_r;

  // Persistent state
  logic [31:0]                     s_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            close_r;
  logic [SUM_W-1:0]                wsum_r;
  logic [SUM_W-1:0]                prev_r;
  logic [bgauge_pkg::TREND_W-1:0]  trend_r;

  // Output register
  logic                            out_valid_r;
  logic [15:0]                     out_filt_r;
  logic [PCT_W-1:0]                out_pct_r;
  logic                            out_chg_r;
  logic [bgauge_pkg::TREND_W-1:0]  out_trend_r;

  // Combinational helpers
  logic [16:0]                 div_sum;
  logic [15:0]                 filt;
  logic [31:0]                 s_eff;
  logic [16:0]                 gain_c;
  logic [SUM_W-1:0]            wsum_base;
  logic [SUM_W-1:0]            prev_eff;
  logic [SUM_W-1:0]            diff_sum;
  logic [15:0]                 span;
  logic [bgauge_pkg::STEP_W-1:0] step;
  logic                        le_empty;
  logic                        ge_full;
  logic [15:0]                 pct_num;
  logic                        div_start;
  logic [NUM_W-1:0]            div_dvd;
  logic [15:0]                 div_dvs;
  logic [bgauge_pkg::DIV_CNT_W-1:0] div_iters;
  logic                        div_done;
  logic [NUM_W-1:0]            div_quo;
  logic                        trend_pos;

  always_comb begin
    div_sum   = {1'b0, top_r} + {1'b0, bot_r};
    filt      = s_r[31:16];
    s_eff     = (s_r == '0) ? {scaled_r, 16'd0} : s_r;
    gain_c    = 17'h10000 - {1'b0, gain_r};
    wsum_base = (cnt_r == CNT_W'(WINDOW_LEN)) ? '0 : wsum_r;
    prev_eff  = (prev_r == '0) ? wsum_r : prev_r;
    diff_sum  = wsum_r - prev_eff;
    span      = full_r - empty_r;
    step      = step_prod_r[bgauge_pkg::PCT_SHIFT +: bgauge_pkg::STEP_W];
    le_empty  = (filt <= empty_r);
    ge_full   = (filt >= full_r);
    pct_num   = filt - empty_r;
    trend_pos = !trend_r[bgauge_pkg::TREND_W-1] && (trend_r != '0);
  end

  // Shared divider: scaling first, then percent
  assign div_start = cmd.div_scale | cmd.pct_div;
  assign div_dvd   = cmd.pct_div ? {pct_num, {(NUM_W-16){1'b0}}} : num_r;
  assign div_dvs   = cmd.pct_div ? {{(16-bgauge_pkg::STEP_W){1'b0}}, step} : bot_r;
  assign div_iters = cmd.pct_div ? bgauge_pkg::DIV_CNT_W'(bgauge_pkg::PCT_ITERS)
                                 : bgauge_pkg::DIV_CNT_W'(bgauge_pkg::SCALE_ITERS);

  bgauge_div #(
    .DVD_W (NUM_W),
    .DVS_W (16)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= bgauge_pkg::TOP_RST;
      bot_r   <= bgauge_pkg::BOTTOM_RST;
      empty_r <= bgauge_pkg::EMPTY_RST;
      full_r  <= bgauge_pkg::FULL_RST;
      gain_r  <= bgauge_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bgauge_pkg::CFG_TOP:    top_r   <= cfg_wdata;
        bgauge_pkg::CFG_BOTTOM: bot_r   <= cfg_wdata;
        bgauge_pkg::CFG_EMPTY:  empty_r <= cfg_wdata;
        bgauge_pkg::CFG_FULL:   full_r  <= cfg_wdata;
        bgauge_pkg::CFG_GAIN:   gain_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-item payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mv_r   <= in_sample_mv;
      soft_r <= in_soft_mode;
      pin_r  <= in_charge_pin;
    end
    if (cmd.num_mul) begin
      num_r <= {{(NUM_W-bgauge_pkg::MV_W){1'b0}}, mv_r} * {{(NUM_W-17){1'b0}}, div_sum};
    end
    if (cmd.scale_sat) begin
      scaled_r <= 16'hFFFF;
    end else if (cmd.scale_quot) begin
      scaled_r <= (div_quo[NUM_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
    end
    if (cmd.flt_mul) begin
      p1_r <= {17'd0, s_eff} * {32'd0, gain_c};
      p2_r <= {16'd0, scaled_r} * {16'd0, gain_r};
    end
    if (cmd.win_add) begin
      step_prod_r <= {17'd0, span} * {16'd0, bgauge_pkg::PCT_RECIP};
    end
    if (cmd.pct_direct) begin
      pct_r <= le_empty ? '0 : bgauge_pkg::PCT_FULL;
    end else if (cmd.pct_quot) begin
      pct_r <= (div_quo > NUM_W'(bgauge_pkg::PCT_FULL)) ? bgauge_pkg::PCT_FULL
                                                       : div_quo[PCT_W-1:0];
    end
  end

  // Filter and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r     <= '0;
      cnt_r   <= CNT_W'(WINDOW_LEN);
      close_r <= 1'b0;
      wsum_r  <= '0;
      prev_r  <= '0;
      trend_r <= '0;
    end else begin
      // Re-prime clears both window sums
      if (cmd.flt_mul && (s_r == '0)) begin
        wsum_r <= '0;
        prev_r <= '0;
      end
      if (cmd.flt_add) begin
        s_r <= p1_r[47:16] + p2_r;
      end
      if (cmd.win_add) begin
        wsum_r  <= wsum_base + {{(SUM_W-16){1'b0}}, filt};
        close_r <= (cnt_r == '0);
        cnt_r   <= (cnt_r == '0) ? CNT_W'(WINDOW_LEN) : cnt_r - CNT_W'(1);
      end
      // Window close: trend from successive sums
      if (cmd.win_close && close_r) begin
        trend_r <= {diff_sum[SUM_W-1], diff_sum};
        prev_r  <= wsum_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_filt_r  <= filt;
      out_pct_r   <= pct_r;
      out_chg_r   <= soft_r ? trend_pos : pin_r;
      out_trend_r <= trend_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_mv    = out_filt_r;
  assign out_charge_percent = out_pct_r;
  assign out_charging       = out_chg_r;
  assign out_window_trend   = out_trend_r;

  // Status
  assign sts.bot_zero = (bot_r == '0);
  assign sts.pct_skip = le_empty || ge_full || (step == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  // Window counter stays within its reload value
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(WINDOW_LEN))
    else $error("window countdown out of range");

  // Trend only moves on a window close
  assert property (@(posedge clk) disable iff (!rst_n) !cmd.win_close |=> $stable(trend_r))
    else $error("trend changed outside window close");

  // Delivered percent never exceeds full scale
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |-> (out_pct_r <= bgauge_pkg::PCT_FULL))
    else $error("percent above 100");

endmodule

@@ src/bgauge_ctrl.sv @@
// Controller: sequences one item through scaling, filter, window and percent.
module bgauge_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bgauge_pkg::sts_t sts,
  output bgauge_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_NUM  = 4'd1;
  localparam logic [3:0] ST_DSC  = 4'd2;
  localparam logic [3:0] ST_WSC  = 4'd3;
  localparam logic [3:0] ST_FMUL = 4'd4;
  localparam logic [3:0] ST_FADD = 4'd5;
  localparam logic [3:0] ST_WIN  = 4'd6;
  localparam logic [3:0] ST_TRD  = 4'd7;
  localparam logic [3:0] ST_PCT  = 4'd8;
  localparam logic [3:0] ST_WPC  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_NUM;
        end
      end
      ST_NUM: begin
        cmd.num_mul = 1'b1;
        state_nxt   = ST_DSC;
      end
      ST_DSC: begin
        if (sts.bot_zero) begin
          cmd.scale_sat = 1'b1;
          state_nxt     = ST_FMUL;
        end else begin
          cmd.div_scale = 1'b1;
          state_nxt     = ST_WSC;
        end
      end
      ST_WSC: begin
        if (sts.div_done) begin
          cmd.scale_quot = 1'b1;
          state_nxt      = ST_FMUL;
        end
      end
      ST_FMUL: begin
        cmd.flt_mul = 1'b1;
        state_nxt   = ST_FADD;
      end
      ST_FADD: begin
        cmd.flt_add = 1'b1;
        state_nxt   = ST_WIN;
      end
      ST_WIN: begin
        cmd.win_add = 1'b1;
        state_nxt   = ST_TRD;
      end
      ST_TRD: begin
        cmd.win_close = 1'b1;
        state_nxt     = ST_PCT;
      end
      ST_PCT: begin
        if (sts.pct_skip) begin
          cmd.pct_direct = 1'b1;
          state_nxt      = ST_OUT;
        end else begin
          cmd.pct_div = 1'b1;
          state_nxt   = ST_WPC;
        end
      end
      ST_WPC: begin
        if (sts.div_done) begin
          cmd.pct_quot = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/battery_gauge_filter_trend.sv @@
// The percent skips its division when the filtered value is at or below empty, at or above full,
// or the step is zero; the shared divider, at one quotient bit per cycle, does both the scaling
// and the percent division. A zero bottom resistor skips the scaling division. One item at a time:
// the next input transfer is taken the cycle after the result is loaded into the output register,
// and that load waits while the output register stays stalled.
// Synchronous active-low reset restores register defaults, empties the filter and window state.
module battery_gauge_filter_trend #(
  parameter int WINDOW_LEN = bgauge_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bgauge_pkg::MV_W-1:0]           in_sample_mv,
  input  logic                                  in_soft_mode,
  input  logic                                  in_charge_pin,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [15:0]                           out_filtered_mv,
  output logic [bgauge_pkg::PCT_W-1:0]          out_charge_percent,
  output logic                                  out_charging,
  output logic signed [bgauge_pkg::TREND_W-1:0] out_window_trend,
  input  logic                                  cfg_we,
  input  logic [bgauge_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bgauge_pkg::CFG_W-1:0]          cfg_wdata
);

  bgauge_pkg::cmd_t cmd;
  bgauge_pkg::sts_t sts;

  bgauge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bgauge_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_sample_mv       (in_sample_mv),
    .in_soft_mode       (in_soft_mode),
    .in_charge_pin      (in_charge_pin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_mv    (out_filtered_mv),
    .out_charge_percent (out_charge_percent),
    .out_charging       (out_charging),
    .out_window_trend   (out_window_trend)
  );

endmodule
